@@ rtl/core/fixed_window_admission_limiter_core_macros.svh @@
// Assertion helpers used by the admission limiter core.
`ifndef FIXED_WINDOW_ADMISSION_LIMITER_CORE_MACROS_SVH
`define FIXED_WINDOW_ADMISSION_LIMITER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FWAL_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FWAL_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fwal_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fwal_pkg;

    // Field widths of the request, result and configuration port.
    localparam int REQ_TIME_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int WIN_LEN_W   = 32;
    localparam int WIN_LIMIT_W = 16;
    localparam int GAP_W       = 32;
    localparam int COOLDOWN_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LIMIT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MINIMUM_GAP     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COOLDOWN_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAINTENANCE_ON  = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [WIN_LEN_W-1:0]   RST_WINDOW_LENGTH   = 32'd10000;
    localparam logic [WIN_LIMIT_W-1:0] RST_WINDOW_LIMIT    = 16'd3;
    localparam logic [GAP_W-1:0]       RST_MINIMUM_GAP     = 32'd500;
    localparam logic [COOLDOWN_W-1:0]  RST_COOLDOWN_LENGTH = 32'd3000;
    localparam logic                   RST_MAINTENANCE_ON  = 1'b0;

    // Reason codes returned with every decision.
    typedef enum logic [2:0] {
        CAUSE_ACCEPTED     = 3'd0,
        CAUSE_MAINTENANCE  = 3'd1,
        CAUSE_COOLDOWN     = 3'd2,
        CAUSE_MIN_GAP      = 3'd3,
        CAUSE_WINDOW_LIMIT = 3'd4
    } cause_t;

    // Current configuration as seen by the policy logic.
    typedef struct packed {
        logic [WIN_LEN_W-1:0]   window_length;
        logic [WIN_LIMIT_W-1:0] grant_ceiling;
        logic [GAP_W-1:0]       minimum_gap;
        logic [COOLDOWN_W-1:0]  cooldown_length;
        logic                   maintenance_on;
    } cfg_t;

    // One decision.
    typedef struct packed {
        logic   granted;
        cause_t cause;
        logic   config_error;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/fwal_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one item per admission request.
interface fwal_req_if;
    logic                            valid;
    logic                            ready;
    logic [fwal_pkg::REQ_TIME_W-1:0] request_time;
    logic                            override_flag;

    modport source (output valid, output request_time, output override_flag, input ready);
    modport sink (input valid, input request_time, input override_flag, output ready);
endinterface

// Result channel: one item per decision.
interface fwal_res_if;
    logic       valid;
    logic       ready;
    logic       granted;
    logic [2:0] cause;
    logic       config_error;

    modport source (output valid, output granted, output cause, output config_error,
                    input ready);
    modport sink (input valid, input granted, input cause, input config_error,
                  output ready);
endinterface

// Configuration write channel.
interface fwal_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [fwal_pkg::CFG_INDEX_W-1:0] index;
    logic [fwal_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/fwal_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fwal_cfg_regs
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    fwal_cfg_if.sink      cfg,
    output fwal_pkg::cfg_t cfg_values
);

    fwal_pkg::cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg.ready  = 1'b1;
    assign cfg_values = cfg_reg;

    // Register file; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length   <= fwal_pkg::RST_WINDOW_LENGTH;
            cfg_reg.grant_ceiling   <= fwal_pkg::RST_WINDOW_LIMIT;
            cfg_reg.minimum_gap     <= fwal_pkg::RST_MINIMUM_GAP;
            cfg_reg.cooldown_length <= fwal_pkg::RST_COOLDOWN_LENGTH;
            cfg_reg.maintenance_on  <= fwal_pkg::RST_MAINTENANCE_ON;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                fwal_pkg::REG_WINDOW_LENGTH:
                    cfg_reg.window_length <= cfg.data[fwal_pkg::WIN_LEN_W-1:0];
                fwal_pkg::REG_WINDOW_LIMIT:
                    cfg_reg.grant_ceiling <= cfg.data[fwal_pkg::WIN_LIMIT_W-1:0];
                fwal_pkg::REG_MINIMUM_GAP:
                    cfg_reg.minimum_gap <= cfg.data[fwal_pkg::GAP_W-1:0];
                fwal_pkg::REG_COOLDOWN_LENGTH:
                    cfg_reg.cooldown_length <= cfg.data[fwal_pkg::COOLDOWN_W-1:0];
                fwal_pkg::REG_MAINTENANCE_ON:
                    cfg_reg.maintenance_on <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fwal_policy.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fwal_policy #(
    parameter int TIME_WIDTH  = 32,
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire fwal_pkg::cfg_t                  cfg_values,
    input  wire logic                            fire,
    input  wire logic [fwal_pkg::REQ_TIME_W-1:0] request_time,
    input  wire logic                            override_flag,
    output fwal_pkg::result_t                    result
);

    // Sums are formed one bit wider than either operand so they never wrap.
    localparam int SUM_W = ((TIME_WIDTH > fwal_pkg::WIN_LEN_W) ? TIME_WIDTH
                                                                : fwal_pkg::WIN_LEN_W) + 1;
    localparam int LIM_W = (COUNT_WIDTH > fwal_pkg::WIN_LIMIT_W) ? COUNT_WIDTH
                                                                 : fwal_pkg::WIN_LIMIT_W;
    localparam logic [SUM_W-1:0] TIME_MAX  = SUM_W'({TIME_WIDTH{1'b1}});
    localparam logic [LIM_W-1:0] COUNT_MAX = LIM_W'({COUNT_WIDTH{1'b1}});

    logic [TIME_WIDTH-1:0]  window_begin_reg, window_begin_next;
    logic [TIME_WIDTH-1:0]  last_grant_time_reg, last_grant_time_next;
    logic                   last_grant_valid_reg, last_grant_valid_next;
    logic [TIME_WIDTH-1:0]  cooldown_end_reg, cooldown_end_next;
    logic [COUNT_WIDTH-1:0] grants_reg, grants_next;

    logic [SUM_W-1:0]       now_ext;
    logic [TIME_WIDTH-1:0]  now_time;
    logic [SUM_W-1:0]       window_end;
    logic                   restart;
    logic [COUNT_WIDTH-1:0] count_eff;
    logic [LIM_W-1:0]       limit_ext;
    logic [LIM_W-1:0]       limit_eff;
    logic signed [SUM_W:0]  now_s;
    logic signed [SUM_W:0]  last_s;
    logic signed [SUM_W:0]  gap_s;
    logic signed [SUM_W:0]  diff_s;
    logic                   gap_short;
    logic [SUM_W-1:0]       cooldown_sum;
    logic [TIME_WIDTH-1:0]  cooldown_sat;
    logic                   cfg_bad;
    logic                   cooling;
    logic                   limit_hit;

    // Timestamp is taken modulo the time range.
    assign now_ext  = SUM_W'(request_time);
    assign now_time = now_ext[TIME_WIDTH-1:0];

    // Window roll-over happens ahead of every check.
    assign window_end = SUM_W'(window_begin_reg) + SUM_W'(cfg_values.window_length);
    assign restart    = (SUM_W'(now_time) >= window_end);
    assign count_eff  = restart ? '0 : grants_reg;

    // The limit is clipped to what the grant counter can hold.
    assign limit_ext = LIM_W'(cfg_values.grant_ceiling);
    assign limit_eff = (limit_ext < COUNT_MAX) ? limit_ext : COUNT_MAX;
    assign limit_hit = (LIM_W'(count_eff) >= limit_eff);

    // Signed gap since the last grant; time running backwards gives a negative gap.
    assign now_s     = $signed({1'b0, SUM_W'(now_time)});
    assign last_s    = $signed({1'b0, SUM_W'(last_grant_time_reg)});
    assign gap_s     = $signed({1'b0, SUM_W'(cfg_values.minimum_gap)});
    assign diff_s    = now_s - last_s;
    assign gap_short = last_grant_valid_reg && (diff_s < gap_s);

    // Cooldown end saturates at the top of the time range.
    assign cooldown_sum = SUM_W'(now_time) + SUM_W'(cfg_values.cooldown_length);
    assign cooldown_sat = (cooldown_sum > TIME_MAX) ? TIME_MAX[TIME_WIDTH-1:0]
                                                    : cooldown_sum[TIME_WIDTH-1:0];

    assign cooling = (now_time < cooldown_end_reg);
    assign cfg_bad = (cfg_values.window_length == '0) || (cfg_values.grant_ceiling == '0);

    // Decision in priority order and the matching state update.
    always_comb
    begin
        window_begin_next     = window_begin_reg;
        last_grant_time_next  = last_grant_time_reg;
        last_grant_valid_next = last_grant_valid_reg;
        cooldown_end_next     = cooldown_end_reg;
        grants_next           = grants_reg;
        result.granted        = 1'b0;
        result.cause          = fwal_pkg::CAUSE_ACCEPTED;
        result.config_error   = 1'b0;

        if (cfg_bad)
        begin
            result.config_error = 1'b1;
        end
        else
        begin
            if (restart)
            begin
                window_begin_next = now_time;
            end
            grants_next = count_eff;

            priority if (cfg_values.maintenance_on && !override_flag)
            begin
                result.cause = fwal_pkg::CAUSE_MAINTENANCE;
            end
            else if (cooling)
            begin
                result.cause = fwal_pkg::CAUSE_COOLDOWN;
            end
            else if (gap_short)
            begin
                result.cause = fwal_pkg::CAUSE_MIN_GAP;
            end
            else if (limit_hit)
            begin
                result.cause      = fwal_pkg::CAUSE_WINDOW_LIMIT;
                cooldown_end_next = cooldown_sat;
            end
            else
            begin
                result.granted        = 1'b1;
                last_grant_time_next  = now_time;
                last_grant_valid_next = 1'b1;
                grants_next           = count_eff + COUNT_WIDTH'(1);
            end
        end
    end

    // Limiter state advances only when a request is decided.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_begin_reg     <= '0;
            last_grant_time_reg  <= '0;
            last_grant_valid_reg <= 1'b0;
            cooldown_end_reg     <= '0;
            grants_reg           <= '0;
        end
        else if (fire)
        begin
            window_begin_reg     <= window_begin_next;
            last_grant_time_reg  <= last_grant_time_next;
            last_grant_valid_reg <= last_grant_valid_next;
            cooldown_end_reg     <= cooldown_end_next;
            grants_reg           <= grants_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fixed_window_admission_limiter_core.sv @@
// A request item waits in the request register until it is decided; its result item then waits in the result register.
// Throughput: one request item per cycle while the result side takes items; the decision and the state update
// are combinational between the request register and the result register.
// Reset (rst_n low, asynchronous): configuration returns to its default values,
// window, grant and cooldown state clear to zero and both stages empty.
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_window_admission_limiter_core_macros.svh"

module fixed_window_admission_limiter_core #(
    parameter int TIME_WIDTH  = 32,
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    fwal_cfg_if.sink  cfg,
    fwal_req_if.sink  req,
    fwal_res_if.source res
);

    fwal_pkg::cfg_t    cfg_values;
    fwal_pkg::result_t decision;

    logic                            s1_valid_reg;
    logic [fwal_pkg::REQ_TIME_W-1:0] s1_time_reg;
    logic                            s1_override_reg;
    logic                            out_valid_reg;
    fwal_pkg::result_t               out_result_reg;
    logic                            advance;

    fwal_cfg_regs u_cfg_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_values (cfg_values)
    );

    fwal_policy #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_policy
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_values    (cfg_values),
        .fire          (advance),
        .request_time  (s1_time_reg),
        .override_flag (s1_override_reg),
        .result        (decision)
    );

    // A registered item is decided when the result register is free or being emptied.
    assign advance   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !s1_valid_reg || advance;

    // Request register occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    // Request payload.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_time_reg     <= req.request_time;
            s1_override_reg <= req.override_flag;
        end
    end

    // Result register occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= decision;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.granted      = out_result_reg.granted;
    assign res.cause        = out_result_reg.cause;
    assign res.config_error = out_result_reg.config_error;

    // A grant always carries the accepted code and no error.
    `FWAL_ASSERT_NOW(a_grant_code, clk, rst_n, res.valid && res.granted, (res.cause == fwal_pkg::CAUSE_ACCEPTED) && !res.config_error, "grant with refusal code or error")
    // A configuration error never grants and carries no refusal code.
    `FWAL_ASSERT_NOW(a_error_code, clk, rst_n, res.valid && res.config_error, !res.granted && (res.cause == fwal_pkg::CAUSE_ACCEPTED), "error result with grant or cause")
    // A decided item shows up in the result register on the next cycle.
    `FWAL_ASSERT_NEXT(a_decide_lands, clk, rst_n, advance, res.valid, "decided item lost before result register")

endmodule

`default_nettype wire

@@ tb/fwal_decision_checker.sv @@
`timescale 1ns / 1ps

// Watches the configuration, request and result channels of the admission
// limiter, keeps its own copy of the limiter state and checks every decision.
module fwal_decision_checker (
    input  logic clk,
    input  logic rst_n,
    fwal_cfg_if  cfg,
    fwal_req_if  req,
    fwal_res_if  res,
    output int   mismatches,
    output int   outstanding
);
    import fwal_pkg::*;

    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Shadow copy of the configuration registers.
    logic [WIN_LEN_W-1:0]   window_length;
    logic [WIN_LIMIT_W-1:0] grant_ceiling;
    logic [GAP_W-1:0]       minimum_gap;
    logic [COOLDOWN_W-1:0]  cooldown_length;
    logic                   maintenance_on;

    // Shadow copy of the window, grant and cooldown state.
    logic [REQ_TIME_W-1:0] window_begin;
    logic [REQ_TIME_W-1:0] last_grant_time;
    logic                  last_grant_valid;
    logic [REQ_TIME_W-1:0] cooldown_end;
    logic [COUNT_W-1:0]    grants_in_window;

    // Decisions predicted for accepted requests, oldest first.
    result_t pending_decisions[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Works out the decision for one request and updates the shadow state.
    function automatic result_t predict_decision(input logic [REQ_TIME_W-1:0] now,
                                                 input logic ovr);
        result_t              verdict;
        logic [COUNT_W-1:0]   cap;
        logic [REQ_TIME_W:0]  window_end;
        logic [REQ_TIME_W:0]  cool_sum;
        longint               since_grant;
        verdict.granted      = 1'b0;
        verdict.cause        = CAUSE_ACCEPTED;
        verdict.config_error = 1'b0;
        // A zero length or limit refuses everything and leaves the state alone.
        if (window_length == '0 || grant_ceiling == '0)
        begin
            verdict.config_error = 1'b1;
            return verdict;
        end
        // The window end is formed one bit wider, so it may lie beyond every timestamp.
        window_end = {1'b0, window_begin} + {1'b0, window_length};
        if ({1'b0, now} >= window_end)
        begin
            window_begin     = now;
            grants_in_window = '0;
        end
        cap = (grant_ceiling < COUNT_MAX) ? grant_ceiling : COUNT_MAX;
        // Signed distance, so a timestamp that goes backwards is always too close.
        since_grant = longint'(now) - longint'(last_grant_time);
        if (maintenance_on && !ovr)
            verdict.cause = CAUSE_MAINTENANCE;
        else if (now < cooldown_end)
            verdict.cause = CAUSE_COOLDOWN;
        else if (last_grant_valid && since_grant < longint'(minimum_gap))
            verdict.cause = CAUSE_MIN_GAP;
        else if (grants_in_window >= cap)
        begin
            verdict.cause = CAUSE_WINDOW_LIMIT;
            cool_sum      = {1'b0, now} + {1'b0, cooldown_length};
            cooldown_end  = cool_sum[REQ_TIME_W] ? '1 : cool_sum[REQ_TIME_W-1:0];
        end
        else
        begin
            last_grant_time  = now;
            last_grant_valid = 1'b1;
            grants_in_window = grants_in_window + 1'b1;
            verdict.granted  = 1'b1;
        end
        return verdict;
    endfunction

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    // Follow register writes, predict each accepted item and check each result item.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            window_length    = RST_WINDOW_LENGTH;
            grant_ceiling    = RST_WINDOW_LIMIT;
            minimum_gap      = RST_MINIMUM_GAP;
            cooldown_length  = RST_COOLDOWN_LENGTH;
            maintenance_on   = RST_MAINTENANCE_ON;
            window_begin     = '0;
            last_grant_time  = '0;
            last_grant_valid = 1'b0;
            cooldown_end     = '0;
            grants_in_window = '0;
            pending_decisions.delete();
            outstanding      = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_WINDOW_LENGTH:   window_length   = cfg.data[WIN_LEN_W-1:0];
                    REG_WINDOW_LIMIT:    grant_ceiling   = cfg.data[WIN_LIMIT_W-1:0];
                    REG_MINIMUM_GAP:     minimum_gap     = cfg.data[GAP_W-1:0];
                    REG_COOLDOWN_LENGTH: cooldown_length = cfg.data[COOLDOWN_W-1:0];
                    REG_MAINTENANCE_ON:  maintenance_on  = cfg.data[0];
                    default: ;
                endcase
            end
            if (res.valid && res.ready)
            begin
                if (pending_decisions.size() == 0)
                begin
                    $display("%0t: unexpected result item, expected none, actual %b/%0d/%b",
                             $time, res.granted, res.cause, res.config_error);
                    mismatches++;
                end
                else
                begin
                    want = pending_decisions.pop_front();
                    if (res.granted !== want.granted)
                        report("granted", 32'(want.granted), 32'(res.granted));
                    if (res.cause !== want.cause)
                        report("cause", 32'(want.cause), 32'(res.cause));
                    if (res.config_error !== want.config_error)
                        report("config_error", 32'(want.config_error),
                               32'(res.config_error));
                end
            end
            if (req.valid && req.ready)
                pending_decisions.push_back(predict_decision(req.request_time,
                                                             req.override_flag));
            outstanding = pending_decisions.size();
        end
    end

endmodule

@@ tb/fixed_window_admission_limiter_core_test.sv @@
`timescale 1ns / 1ps

module fixed_window_admission_limiter_core_test;
    import fwal_pkg::*;

    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 140;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_requests;
    int   mismatches;
    int   outstanding;
    logic [REQ_TIME_W-1:0] clock_ms;

    fwal_cfg_if cfg();
    fwal_req_if req();
    fwal_res_if res();

    fixed_window_admission_limiter_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .res   (res)
    );

    fwal_decision_checker decision_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .req         (req),
        .res         (res),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the handshakes hang.
    initial
    begin
        #2ms;
        $display("FAIL fixed_window_admission_limiter_core");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin : result_sink
        int served;
        int stall_left;
        served     = 0;
        stall_left = 0;
        res.ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (served != hold_requests)
            begin
                served     = hold_requests;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic void set_idling(input int phase);
        case (phase * 3 / PHASES)
            0:
            begin
                send_idle_pct = 19;
                recv_idle_pct = 54;
            end
            1:
            begin
                send_idle_pct = 54;
                recv_idle_pct = 19;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endfunction

    // Offers one request item, with random idle cycles first, and waits until it is taken.
    task automatic send_request(input logic [REQ_TIME_W-1:0] stamp, input logic ovr);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.request_time  <= stamp;
        req.override_flag <= ovr;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
    endtask

    // Lets every outstanding decision come back, then lets the clock run on before returning.
    task automatic wait_idle();
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    // Rewrites all registers while the limiter is idle; the ignored write goes last
    // so that an aliased index would corrupt a live register.
    task automatic apply_settings(input logic [WIN_LEN_W-1:0] len,
                                  input logic [WIN_LIMIT_W-1:0] lim,
                                  input logic [GAP_W-1:0] gap,
                                  input logic [COOLDOWN_W-1:0] cool,
                                  input logic maint);
        req.valid <= 1'b0;
        wait_idle();
        write_reg(REG_WINDOW_LENGTH, len);
        write_reg(REG_WINDOW_LIMIT, {16'b0, lim});
        write_reg(REG_MINIMUM_GAP, gap);
        write_reg(REG_COOLDOWN_LENGTH, cool);
        write_reg(REG_MAINTENANCE_ON, {31'b0, maint});
        write_reg(REG_MAINTENANCE_ON + CFG_INDEX_W'($urandom_range(1, 3)), $urandom);
        cfg.valid <= 1'b0;
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic [WIN_LEN_W-1:0]   len;
        logic [WIN_LIMIT_W-1:0] lim;
        logic [GAP_W-1:0]       gap;
        logic [COOLDOWN_W-1:0]  cool;
        logic                   maint;
        logic                   ovr;
        int                     step_max;
        int                     kind;
        int                     waited;
        bit                     stuck;

        cfg.valid         = 1'b0;
        cfg.index         = REG_WINDOW_LENGTH;
        cfg.data          = '0;
        req.valid         = 1'b0;
        req.request_time  = '0;
        req.override_flag = 1'b0;
        rst_n             = 1'b0;
        hold_requests     = 0;
        clock_ms          = '0;
        stuck             = 1'b0;
        set_idling(0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Settings straight out of reset: grants, gap refusal, limit and cooldown,
        // window restart exactly at its end, and a timestamp that goes backwards.
        send_request(32'd0, 1'b0);
        send_request(32'd100, 1'b1);
        send_request(32'd600, 1'b0);
        send_request(32'd1200, 1'b0);
        send_request(32'd1800, 1'b0);
        send_request(32'd2000, 1'b0);
        send_request(32'd5000, 1'b0);
        send_request(32'd10000, 1'b0);
        send_request(32'd9000, 1'b0);

        // Window end beyond the time range, maintenance, and a zero gap that still
        // refuses a timestamp earlier than the last grant.
        apply_settings('1, '1, '0, 32'd3000, 1'b1);
        send_request(32'd20000, 1'b0);
        send_request(32'd9500, 1'b1);
        send_request(32'd10000, 1'b1);

        // Invalid length, then invalid limit.
        apply_settings('0, 16'd3, 32'd500, 32'd3000, 1'b0);
        send_request(32'd30000, 1'b0);
        send_request(32'd0, 1'b1);
        apply_settings(32'd10, '0, 32'd500, 32'd3000, 1'b0);
        send_request(32'd40000, 1'b1);

        // Shortest window and limit with no gap and no cooldown.
        apply_settings(32'd1, 16'd1, '0, '0, 1'b0);
        send_request(32'd50000, 1'b0);
        send_request(32'd50000, 1'b0);
        send_request(32'd50001, 1'b0);
        clock_ms = 32'd50001;

        // Random phases; the last one runs across the wrap of the time range.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       len = '1;
                1:       len = 32'd1;
                default: len = $urandom_range(2, 300);
            endcase
            case ($urandom_range(0, 5))
                0:       lim = '1;
                1:       lim = 16'd1;
                default: lim = 16'($urandom_range(2, 6));
            endcase
            case ($urandom_range(0, 7))
                0:       gap = '0;
                1:       gap = '1;
                default: gap = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 7))
                0:       cool = '0;
                1:       cool = '1;
                default: cool = $urandom_range(1, 200);
            endcase
            if ($urandom_range(0, 15) == 0)
                len = '0;
            if ($urandom_range(0, 15) == 0)
                lim = '0;
            maint = ($urandom_range(0, 3) == 0);
            apply_settings(len, lim, gap, cool, maint);
            set_idling(phase);
            step_max = $urandom_range(5, 80);
            if (phase == PHASES - 1)
                clock_ms = '1 - $urandom_range(0, 3000);
            else
                clock_ms = clock_ms + $urandom_range(0, 100000);

            // Hold the result side off while requests keep coming.
            if (phase == 1 || phase == PHASES - 3)
                hold_requests++;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                ovr  = maint ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 3) == 0);
                kind = $urandom_range(0, 99);
                if (kind < 80)
                begin
                    clock_ms = clock_ms + $urandom_range(0, step_max);
                    send_request(clock_ms, ovr);
                end
                else if (kind < 88)
                begin
                    clock_ms = clock_ms - $urandom_range(0, step_max);
                    send_request(clock_ms, ovr);
                end
                else if (kind < 95)
                    send_request(clock_ms, ovr);
                else
                    send_request($urandom, ovr);
            end
        end

        // Cooldown that saturates at the top of the time range; this keeps the limiter in
        // cooldown for every timestamp below the top value, so it comes last.
        apply_settings(32'd1, 16'd1, '0, '1, 1'b0);
        set_idling(0);
        send_request(32'hFFFF_FFF0, 1'b0);
        send_request(32'hFFFF_FFF0, 1'b0);
        send_request(32'hFFFF_FFF8, 1'b1);
        send_request(32'hFFFF_FFFF, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b0);
        req.valid <= 1'b0;

        // Drain the remaining decisions.
        waited = 0;
        while (outstanding != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (outstanding != 0)
        begin
            $display("%0t: %0d expected result items never arrived", $time, outstanding);
            stuck = 1'b1;
        end

        if (mismatches == 0 && !stuck)
            $display("PASS fixed_window_admission_limiter_core");
        else
            $display("FAIL fixed_window_admission_limiter_core");
        $finish;
    end

endmodule
